@@ rtl/cascade_attitude_pid_assert.svh @@
// Assertion macros for the attitude controller
`ifndef CASCADE_ATTITUDE_PID_ASSERT_SVH
`define CASCADE_ATTITUDE_PID_ASSERT_SVH

// Implication checked every clock edge outside reset
`define CAP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define CAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cap_pkg.sv @@
`timescale 1ns / 1ps
package cap_pkg;
   localparam int NUM_AXES = 3;
   localparam int NUM_REGS = 5;
   localparam int REG_W = 48;
   localparam int IDX_W = 3;
   localparam int SIG_W = 32;
   localparam int DT_W = 16;
   localparam int GAIN_W = 16;

   typedef enum logic [IDX_W-1:0] {
      REG_OUTER_KP = 3'd0,
      REG_INNER_KP = 3'd1,
      REG_INNER_KD = 3'd2,
      REG_INNER_KI = 3'd3,
      REG_INT_LIM  = 3'd4
   } reg_idx_type;

   typedef enum logic [3:0] {
      OP_CMD, OP_ERR, OP_DIV_START, OP_INTEG, OP_CLAMP, OP_DERIV,
      OP_P, OP_D, OP_I, OP_TORQUE, OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  axis;
      logic        load;
      logic        clear_flags;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

   function automatic logic signed [SIG_W-1:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[SIG_W-1:0];
   endfunction
endpackage

@@ rtl/cap_if.sv @@
`timescale 1ns / 1ps
interface cap_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] att_err_roll;
   logic signed [31:0] att_err_pitch;
   logic signed [31:0] att_err_yaw;
   logic signed [31:0] rate_roll;
   logic signed [31:0] rate_pitch;
   logic signed [31:0] rate_yaw;
   logic [15:0] step_time;
   modport source (output valid, att_err_roll, att_err_pitch, att_err_yaw,
                   rate_roll, rate_pitch, rate_yaw, step_time, input ready);
   modport sink (input valid, att_err_roll, att_err_pitch, att_err_yaw,
                 rate_roll, rate_pitch, rate_yaw, step_time, output ready);
endinterface

interface cap_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] torque_roll;
   logic signed [31:0] torque_pitch;
   logic signed [31:0] torque_yaw;
   logic saturated;
   logic zero_step;
   modport source (output valid, torque_roll, torque_pitch, torque_yaw,
                   saturated, zero_step, input ready);
   modport sink (input valid, torque_roll, torque_pitch, torque_yaw,
                 saturated, zero_step, output ready);
endinterface

interface cap_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/cap_div.sv @@
`timescale 1ns / 1ps
// Signed 49/16 restoring divider, one quotient bit per cycle, truncates toward zero.
module cap_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [48:0]  dividend,
   input  logic [15:0]         divisor,
   output logic                busy,
   output logic signed [49:0]  quotient
);
   import cap_pkg::*;
   logic [48:0] num_ff, num_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in;
   logic [16:0] trial;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; busy_in = busy_ff;
      trial = {rem_ff[15:0], num_ff[48]};
      if (start) begin
         num_in = dividend[48] ? 49'(-dividend) : dividend;
         neg_in = dividend[48];
         den_in = divisor;
         rem_in = '0;
         cnt_in = 6'd49;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[47:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[47:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign quotient = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});
endmodule

@@ rtl/cap_datapath.sv @@
`timescale 1ns / 1ps
module cap_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  cap_pkg::cmd_type      cmd,
   output cap_pkg::status_type   status,
   input  logic [47:0]           reg_kpo,
   input  logic [47:0]           reg_kpi,
   input  logic [47:0]           reg_kdi,
   input  logic [47:0]           reg_kii,
   input  logic [47:0]           reg_lim,
   input  logic signed [31:0]    in_att [3],
   input  logic signed [31:0]    in_rate [3],
   input  logic [15:0]           in_dt,
   output logic signed [31:0]    torque [3],
   output logic                  sat_flag,
   output logic                  zero_flag
);
   import cap_pkg::*;
   logic signed [31:0] att_ff [3];
   logic signed [31:0] rate_ff [3];
   logic [15:0]        dt_ff;
   logic signed [31:0] integ_ff [3];
   logic signed [31:0] last_ff [3];
   logic signed [31:0] tq_ff [3];
   logic signed [31:0] err_ff, deriv_ff;
   logic signed [33:0] integ_raw_ff;
   logic signed [47:0] prod_ff;
   logic signed [49:0] acc_ff;
   logic               sat_ff, zero_ff;

   logic signed [15:0] kpo, kpi, kdi, kii;
   logic signed [24:0] lim;
   logic signed [31:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [48:0] mul_p;
   logic signed [48:0] diff;
   logic               div_busy;
   logic signed [49:0] quo;
   logic signed [49:0] acc_sum;
   logic signed [33:0] integ_sum;
   logic signed [41:0] acc_sh;

   always_comb begin
      kpo = reg_kpo[16*cmd.axis +: 16];
      kpi = reg_kpi[16*cmd.axis +: 16];
      kdi = reg_kdi[16*cmd.axis +: 16];
      kii = reg_kii[16*cmd.axis +: 16];
      lim = $signed({1'b0, reg_lim[16*cmd.axis +: 16], 8'd0});
      mul_a = err_ff;
      mul_b = $signed({kpo[15], kpo});
      case (cmd.op)
         OP_CMD: begin mul_a = att_ff[cmd.axis]; mul_b = $signed({kpo[15], kpo}); end
         OP_INTEG: begin mul_a = err_ff; mul_b = $signed({1'b0, dt_ff}); end
         OP_P: begin mul_a = err_ff; mul_b = $signed({kpi[15], kpi}); end
         OP_D: begin mul_a = deriv_ff; mul_b = $signed({kdi[15], kdi}); end
         OP_I: begin mul_a = integ_ff[cmd.axis]; mul_b = $signed({kii[15], kii}); end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
      diff = $signed({{17{err_ff[31]}}, err_ff}) - $signed({{17{last_ff[cmd.axis][31]}},
             last_ff[cmd.axis]});
      acc_sum = acc_ff + $signed({{2{prod_ff[47]}}, prod_ff});
      integ_sum = $signed({{2{integ_ff[cmd.axis][31]}}, integ_ff[cmd.axis]}) + integ_raw_ff;
      acc_sh = 42'(acc_ff >>> 8);
   end

   cap_div u_div (
      .clock(clock), .reset(reset), .start(cmd.op == OP_DIV_START),
      .dividend(49'(diff <<< 16)), .divisor(dt_ff), .busy(div_busy), .quotient(quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         att_ff <= in_att; rate_ff <= in_rate; dt_ff <= in_dt;
      end
      if (cmd.clear_flags) begin
         sat_ff <= 1'b0;
         zero_ff <= (in_dt == 16'd0);
      end
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            integ_ff[i] <= '0;
            last_ff[i] <= '0;
         end
      end else begin
         case (cmd.op)
            OP_CMD: prod_ff <= mul_p[47:0];
            OP_ERR: err_ff <= sat32(64'(sat32(64'(prod_ff >>> 8))) - 64'(rate_ff[cmd.axis]));
            OP_INTEG: integ_raw_ff <= 34'(mul_p >>> 16);
            OP_CLAMP: begin
               if (integ_sum > 34'(lim)) integ_ff[cmd.axis] <= 32'(lim);
               else if (integ_sum < -34'(lim)) integ_ff[cmd.axis] <= 32'(-lim);
               else integ_ff[cmd.axis] <= integ_sum[31:0];
               acc_ff <= '0;
               prod_ff <= '0;
            end
            OP_DERIV: deriv_ff <= (dt_ff == 16'd0) ? 32'sd0 : sat32(64'(quo));
            OP_P, OP_D, OP_I: begin prod_ff <= mul_p[47:0]; acc_ff <= acc_sum; end
            OP_TORQUE: begin
               tq_ff[cmd.axis] <= sat32(64'(acc_sh));
               last_ff[cmd.axis] <= err_ff;
               if (acc_sh > 42'sd2147483647 || acc_sh < -42'sd2147483648) sat_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign status.div_busy = div_busy;
   assign torque = tq_ff;
   assign sat_flag = sat_ff;
   assign zero_flag = zero_ff;
endmodule

@@ rtl/cap_ctrl.sv @@
`timescale 1ns / 1ps
module cap_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cap_pkg::cmd_type     cmd,
   input  cap_pkg::status_type  status
);
   import cap_pkg::*;
   typedef enum logic [3:0] {
      S_IDLE, S_CMD, S_ERR, S_DIVS, S_DIVW, S_INTEG, S_CLAMP, S_DERIV,
      S_P, S_D, S_I, S_ACC, S_TQ, S_OUT
   } state_type;
   state_type state_ff;
   logic [1:0] axis_ff;
   logic       rsp_valid_ff;

   always_comb begin
      cmd = '{op: OP_NONE, axis: axis_ff, load: 1'b0, clear_flags: 1'b0};
      case (state_ff)
         S_IDLE: if (req_valid) begin cmd.load = 1'b1; cmd.clear_flags = 1'b1; end
         S_CMD: cmd.op = OP_CMD;
         S_ERR: cmd.op = OP_ERR;
         S_DIVS: cmd.op = OP_DIV_START;
         S_INTEG: cmd.op = OP_INTEG;
         S_CLAMP: cmd.op = OP_CLAMP;
         S_DERIV: cmd.op = OP_DERIV;
         S_P: cmd.op = OP_P;
         S_D: cmd.op = OP_D;
         S_I: cmd.op = OP_I;
         S_ACC: cmd.op = OP_I;
         S_TQ: cmd.op = OP_TORQUE;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; axis_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin state_ff <= S_CMD; axis_ff <= '0; end
            S_CMD: state_ff <= S_ERR;
            S_ERR: state_ff <= S_DIVS;
            S_DIVS: state_ff <= S_INTEG;
            S_INTEG: state_ff <= S_CLAMP;
            S_CLAMP: state_ff <= S_DIVW;
            S_DIVW: if (!status.div_busy) state_ff <= S_DERIV;
            S_DERIV: state_ff <= S_P;
            S_P: state_ff <= S_D;
            S_D: state_ff <= S_I;
            S_I: state_ff <= S_ACC;
            S_ACC: state_ff <= S_TQ;
            S_TQ: begin
               if (axis_ff == 2'd2) begin state_ff <= S_OUT; rsp_valid_ff <= 1'b1; end
               else begin axis_ff <= axis_ff + 2'd1; state_ff <= S_CMD; end
            end
            S_OUT: if (rsp_ready) begin rsp_valid_ff <= 1'b0; state_ff <= S_IDLE; end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

@@ rtl/cascade_attitude_pid.sv @@
`timescale 1ns / 1ps
// Three-axis cascaded attitude controller (outer P, inner PID).
// Channels: req_ carries attitude errors, body rates and step time; rsp_ returns
// three saturated torques with saturated and zero_step flags; csr_ writes the
// five 48-bit gain/limit registers (index 0..4, others ignored).
// One transaction in, one out. Each axis waits on the bit-serial divider of the
// derivative path (49 steps, overlapped with the integrator and clamp states).
// The result is valid once all three axes are done.
// The result holds on rsp_ until rsp_ready; no new item is taken meanwhile.
// Reset clears the configuration registers, integrators and the previous rate errors.
// Configuration must be written only while the block is idle; the block does not enforce this.
module cascade_attitude_pid (
   input logic clock,
   input logic reset,
   cap_req_if.sink   req,
   cap_rsp_if.source rsp,
   cap_csr_if.sink   csr
);
   import cap_pkg::*;
   `include "cascade_attitude_pid_assert.svh"
   logic [47:0] regs_ff [NUM_REGS];
   cmd_type cmd;
   status_type status;
   logic signed [31:0] att [3];
   logic signed [31:0] rate [3];
   logic signed [31:0] tq [3];

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            REG_OUTER_KP: regs_ff[REG_OUTER_KP] <= csr.data;
            REG_INNER_KP: regs_ff[REG_INNER_KP] <= csr.data;
            REG_INNER_KD: regs_ff[REG_INNER_KD] <= csr.data;
            REG_INNER_KI: regs_ff[REG_INNER_KI] <= csr.data;
            REG_INT_LIM:  regs_ff[REG_INT_LIM] <= csr.data;
            default: ;
         endcase
      end
   end

   assign att[0] = req.att_err_roll; assign att[1] = req.att_err_pitch;
   assign att[2] = req.att_err_yaw;
   assign rate[0] = req.rate_roll; assign rate[1] = req.rate_pitch;
   assign rate[2] = req.rate_yaw;

   cap_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .cmd(cmd), .status(status)
   );

   cap_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .reg_kpo(regs_ff[REG_OUTER_KP]), .reg_kpi(regs_ff[REG_INNER_KP]),
      .reg_kdi(regs_ff[REG_INNER_KD]), .reg_kii(regs_ff[REG_INNER_KI]),
      .reg_lim(regs_ff[REG_INT_LIM]), .in_att(att), .in_rate(rate),
      .in_dt(req.step_time), .torque(tq), .sat_flag(rsp.saturated),
      .zero_flag(rsp.zero_step)
   );

   assign rsp.torque_roll = tq[0];
   assign rsp.torque_pitch = tq[1];
   assign rsp.torque_yaw = tq[2];

   `CAP_ASSERT_IMPLY(a_no_overlap, clock, reset, rsp.valid, !req.ready, "input taken while result pending")
   `CAP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid, "result dropped")
endmodule
